### rtl/core/equirect_to_cube_face_coords_assert.svh
// Assertion macros for the equirectangular-to-cube coordinate generator
`ifndef EQUIRECT_TO_CUBE_FACE_COORDS_ASSERT_SVH
`define EQUIRECT_TO_CUBE_FACE_COORDS_ASSERT_SVH
// assert that an antecedent implies a consequent in the next cycle
`define E2C_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
// assert that a condition holds every cycle out of reset
`define E2C_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");
`endif

### rtl/core/e2c_pkg.sv
// Shared constants, types and functions for the cube-face coordinate generator
package e2c_pkg;
   localparam int FaceSizeDef = 1024;
   localparam int CordicStepsDef = 16;
   localparam int CoordFracBitsDef = 8;
   localparam int VecW = 18;             // Q1.16 signed vector component
   localparam int CordW = 30;            // CORDIC datapath width (vector * 256 plus growth)
   localparam int AngW = 20;             // accumulator width before saturation
   localparam int OutW = 22;
   localparam int SizeW = 14;
   localparam logic [1:0] FaceLeft = 2'd0;
   localparam logic [1:0] FaceFront = 2'd1;
   localparam logic [1:0] FaceRight = 2'd2;
   localparam logic CsrWidth = 1'b0;
   localparam logic CsrHeight = 1'b1;

   typedef struct packed {
      logic signed [CordW-1:0] cx;
      logic signed [CordW-1:0] cy;
      logic signed [AngW-1:0]  z;
   } cordic_lane_type;

   function automatic logic signed [AngW-1:0] atan_unit(input int i);
      logic signed [AngW-1:0] t;
      begin
         unique case (i)
            0: t = 20'sd32768; 1: t = 20'sd19344; 2: t = 20'sd10221;
            3: t = 20'sd5188;  4: t = 20'sd2604;  5: t = 20'sd1303;
            6: t = 20'sd652;   7: t = 20'sd326;   8: t = 20'sd163;
            9: t = 20'sd81;   10: t = 20'sd41;   11: t = 20'sd20;
            12: t = 20'sd10;  13: t = 20'sd5;    14: t = 20'sd3;
            15: t = 20'sd1;   16: t = 20'sd1;
            default: t = '0;
         endcase
         return t;
      end
   endfunction
endpackage

### rtl/core/e2c_cordic_cell.sv
// One CORDIC vectoring micro-rotation cell, registered
module e2c_cordic_cell import e2c_pkg::*; #(
   parameter int STEP = 0
) (
   input  logic            clock,
   input  logic            enable,
   input  cordic_lane_type lane_in,
   output cordic_lane_type lane_out
);
   cordic_lane_type lane_ff, lane_in_nx;
   logic signed [CordW-1:0] dx, dy;

   always_comb begin
      dx = lane_in.cy >>> STEP;
      dy = lane_in.cx >>> STEP;
      lane_in_nx = lane_in;
      if (!lane_in.cy[CordW-1]) begin
         lane_in_nx.cx = lane_in.cx + dx;
         lane_in_nx.cy = lane_in.cy - dy;
         lane_in_nx.z  = lane_in.z + atan_unit(STEP);
      end else begin
         lane_in_nx.cx = lane_in.cx - dx;
         lane_in_nx.cy = lane_in.cy + dy;
         lane_in_nx.z  = lane_in.z - atan_unit(STEP);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         lane_ff <= lane_in_nx;
      end
   end
   assign lane_out = lane_ff;
endmodule

### rtl/core/e2c_sqrt_cell.sv
// One restoring square-root step cell (one result bit per cell, two operand bits per step)
module e2c_sqrt_cell import e2c_pkg::*; #(
   parameter int STEP = 0,
   parameter int SW = 38
) (
   input  logic          clock,
   input  logic          enable,
   input  logic [SW-1:0] rem_in,
   input  logic [SW-1:0] res_in,
   output logic [SW-1:0] rem_out,
   output logic [SW-1:0] res_out
);
   localparam logic [SW-1:0] Bit = SW'(1) << (36 - 2 * STEP);
   logic [SW-1:0] rem_ff, res_ff, rem_in_nx, res_in_nx;

   always_comb begin
      if (rem_in >= res_in + Bit) begin
         rem_in_nx = rem_in - (res_in + Bit);
         res_in_nx = (res_in >> 1) + Bit;
      end else begin
         rem_in_nx = rem_in;
         res_in_nx = res_in >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff <= rem_in_nx;
         res_ff <= res_in_nx;
      end
   end
   assign rem_out = rem_ff;
   assign res_out = res_ff;
endmodule

### rtl/core/equirect_to_cube_face_coords.sv
// Top level: cube-face pixel to equirectangular source coordinate generator
// One transaction in, one out. Every cycle a new pixel may enter while the chain is not
// stalled: the datapath is a chain of registered cells (an input stage, 19 square-root steps
// with the vector carried alongside by a matching shift line, a pre-rotation stage, then
// CORDIC_STEPS longitude and latitude rotation cells running side by side, then two scaling
// stages); throughput is one transaction per clock while not stalled. The whole chain stalls
// only while the output register holds a result that is not taken and the next result is
// already at the end of the chain. req_tready follows rsp_tready combinationally in that
// case. Frame size registers written over csr_ are taken only when the pipeline is empty.
module equirect_to_cube_face_coords import e2c_pkg::*; #(
   parameter int FACE_SIZE = FaceSizeDef,
   parameter int CORDIC_STEPS = CordicStepsDef,
   parameter int COORD_FRAC_BITS = CoordFracBitsDef
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [1:0] face, [11:2] row, [21:12] col
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [21:0] src_x, [43:22] src_y
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [13:0] csr_data
);
`include "equirect_to_cube_face_coords_assert.svh"
   localparam int FaceBits = $clog2(FACE_SIZE);
   // floor(idx * 2^17 / FACE_SIZE) as an exact reciprocal multiply, idx * 2^17 < 2^29
   localparam longint NormMul = ((longint'(1) << (29 + FaceBits)) + longint'(FACE_SIZE) - 1)
                                / longint'(FACE_SIZE);
   localparam int NormShift = 12 + FaceBits;
   localparam int SqSteps = 19;
   localparam int SW = 38;
   localparam int Depth = 1 + SqSteps + 1 + CORDIC_STEPS + 2;

   logic [SizeW-1:0] width_ff, height_ff;
   logic [Depth-1:0] vld_ff;
   logic advance;
   logic skid_full_ff;
   logic [47:0] skid_ff;

   // the pipeline moves when the output slot can take the head
   assign advance = !vld_ff[Depth-1] || !skid_full_ff || rsp_tready;
   assign req_tready = advance;
   assign csr_ready = (vld_ff == '0) && !skid_full_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= 14'd3840;
         height_ff <= 14'd1920;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CsrWidth:  width_ff <= csr_data;
            CsrHeight: height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[Depth-2:0], req_tvalid};
      end
   end

   // stage 0: normalised vector
   logic [1:0] face;
   logic [9:0] row_i, col_i;
   logic [FaceBits-1:0] rs, cs;
   logic signed [VecW-1:0] xn, yn;
   logic signed [VecW-1:0] vx_ff, vy_ff, vz_ff;
   assign face = req_tdata[1:0];
   assign row_i = req_tdata[11:2];
   assign col_i = req_tdata[21:12];
   always_comb begin
      rs = (32'(row_i) > FACE_SIZE - 1) ? FaceBits'(FACE_SIZE - 1) : FaceBits'(row_i);
      cs = (32'(col_i) > FACE_SIZE - 1) ? FaceBits'(FACE_SIZE - 1) : FaceBits'(col_i);
      yn = VecW'((64'(rs) * 64'(NormMul)) >> NormShift) - VecW'(65536);
      xn = VecW'((64'(cs) * 64'(NormMul)) >> NormShift) - VecW'(65536);
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         vy_ff <= yn;
         priority if (face == FaceLeft) begin
            vx_ff <= -VecW'(65536); vz_ff <= xn;
         end else if (face == FaceRight) begin
            vx_ff <= VecW'(65536); vz_ff <= -xn;
         end else begin
            vx_ff <= xn; vz_ff <= VecW'(65536);
         end
      end
   end

   // square-root cell chain, vectors ride alongside
   logic [SW-1:0] rem_w [SqSteps+1];
   logic [SW-1:0] res_w [SqSteps+1];
   logic signed [VecW-1:0] sx_ff [SqSteps], sy_ff [SqSteps], sz_ff [SqSteps];
   assign rem_w[0] = SW'(36'(vx_ff * vx_ff)) + SW'(36'(vz_ff * vz_ff));
   assign res_w[0] = '0;
   for (genvar g = 0; g < SqSteps; g++) begin : g_sq
      e2c_sqrt_cell #(.STEP(g), .SW(SW)) u_cell (
         .clock(clock), .enable(advance),
         .rem_in(rem_w[g]), .res_in(res_w[g]),
         .rem_out(rem_w[g+1]), .res_out(res_w[g+1]));
      always_ff @(posedge clock) begin
         if (advance) begin
            sx_ff[g] <= (g == 0) ? vx_ff : sx_ff[g-1 < 0 ? 0 : g-1];
            sy_ff[g] <= (g == 0) ? vy_ff : sy_ff[g-1 < 0 ? 0 : g-1];
            sz_ff[g] <= (g == 0) ? vz_ff : sz_ff[g-1 < 0 ? 0 : g-1];
         end
      end
   end

   // pre-rotation into the right half plane
   function automatic cordic_lane_type pre_rot(input logic signed [CordW-1:0] yv,
                                               input logic signed [CordW-1:0] xv);
      cordic_lane_type l;
      begin
         l.cx = xv; l.cy = yv; l.z = '0;
         if (xv < 0) begin
            if (yv >= 0) begin
               l.cx = yv; l.cy = -xv; l.z = AngW'(65536);
            end else begin
               l.cx = -yv; l.cy = xv; l.z = -AngW'(65536);
            end
         end
         return l;
      end
   endfunction

   cordic_lane_type th_ff, ph_ff;
   logic zero_th_ff, zero_ph_ff;
   logic signed [CordW-1:0] ax, az, ay, ar;
   always_comb begin
      ax = CordW'(sx_ff[SqSteps-1]) <<< 8;
      az = CordW'(sz_ff[SqSteps-1]) <<< 8;
      ay = CordW'(sy_ff[SqSteps-1]) <<< 8;
      ar = CordW'(res_w[SqSteps][18:0]) <<< 8;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         th_ff <= pre_rot(ax, az);
         ph_ff <= pre_rot(ay, ar);
         zero_th_ff <= (ax == 0) && (az == 0);
         zero_ph_ff <= (ay == 0) && (ar == 0);
      end
   end

   cordic_lane_type th_w [CORDIC_STEPS+1];
   cordic_lane_type ph_w [CORDIC_STEPS+1];
   logic zt_ff [CORDIC_STEPS], zp_ff [CORDIC_STEPS];
   assign th_w[0] = th_ff;
   assign ph_w[0] = ph_ff;
   for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cr
      e2c_cordic_cell #(.STEP(g)) u_th (
         .clock(clock), .enable(advance), .lane_in(th_w[g]), .lane_out(th_w[g+1]));
      e2c_cordic_cell #(.STEP(g)) u_ph (
         .clock(clock), .enable(advance), .lane_in(ph_w[g]), .lane_out(ph_w[g+1]));
      always_ff @(posedge clock) begin
         if (advance) begin
            zt_ff[g] <= (g == 0) ? zero_th_ff : zt_ff[g-1 < 0 ? 0 : g-1];
            zp_ff[g] <= (g == 0) ? zero_ph_ff : zp_ff[g-1 < 0 ? 0 : g-1];
         end
      end
   end

   // saturate angles, offset, multiply by frame size
   function automatic logic [17:0] sat_ang(input logic signed [AngW-1:0] z, input logic zr);
      logic signed [AngW-1:0] s;
      begin
         s = z;
         if (zr) s = '0;
         else if (z > $signed(AngW'(131071))) s = AngW'(131071);
         else if (z < -$signed(AngW'(131072))) s = -AngW'(131072);
         return 18'(s);
      end
   endfunction
   logic [17:0] th_s, ph_s;
   logic [18:0] u_w, v_w;
   logic [32:0] px_ff, py_ff;
   logic [SizeW-1:0] w_ff, h_ff;
   assign th_s = sat_ang(th_w[CORDIC_STEPS].z, zt_ff[CORDIC_STEPS-1]);
   assign ph_s = sat_ang(ph_w[CORDIC_STEPS].z, zp_ff[CORDIC_STEPS-1]);
   assign u_w = 19'($signed(th_s)) + 19'd131072;
   assign v_w = 19'($signed(ph_s)) + 19'd65536;
   always_ff @(posedge clock) begin
      if (advance) begin
         px_ff <= 33'(u_w) * 33'(width_ff);
         py_ff <= 33'(v_w) * 33'(height_ff);
         w_ff <= width_ff;
         h_ff <= height_ff;
      end
   end

   localparam int ShX = 18 - COORD_FRAC_BITS;
   localparam int ShY = 17 - COORD_FRAC_BITS;
   logic [32:0] qx, qy, lx, ly;
   logic [OutW-1:0] ox, oy;
   logic [47:0] out_ff;
   always_comb begin
      qx = (px_ff + (33'(1) << (ShX - 1))) >> ShX;
      qy = (py_ff + (33'(1) << (ShY - 1))) >> ShY;
      lx = 33'(w_ff) << COORD_FRAC_BITS;
      ly = 33'(h_ff) << COORD_FRAC_BITS;
      if (qx > lx) qx = lx;
      if (qy > ly) qy = ly;
      ox = (qx > 33'(4194303)) ? OutW'(4194303) : OutW'(qx);
      oy = (qy > 33'(4194303)) ? OutW'(4194303) : OutW'(qy);
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= {4'd0, oy, ox};
      end
   end

   // output slot: holds its transaction until taken, loads only a valid head
   always_ff @(posedge clock) begin
      if (reset) begin
         skid_full_ff <= 1'b0;
      end else if (advance && vld_ff[Depth-1]) begin
         skid_full_ff <= 1'b1;
      end else if (rsp_tready) begin
         skid_full_ff <= 1'b0;
      end
   end
   always_ff @(posedge clock) begin
      if (advance && vld_ff[Depth-1]) begin
         skid_ff <= out_ff;
      end
   end
   assign rsp_tvalid = skid_full_ff;
   assign rsp_tdata = skid_ff;

   `E2C_ASSERT_NEXT(a_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `E2C_ASSERT_NEXT(a_data, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata))
   `E2C_ASSERT_ALWAYS(a_csr_idle, clock, reset, !(csr_ready && rsp_tvalid))
endmodule

### tb/sv/equirect_to_cube_face_coords_tb.sv
// Testbench for the cube-face to equirectangular coordinate generator
`timescale 1ns / 100ps

// Directed pixels go first, then random ones. Each accepted pixel is predicted on the spot
// with a bit-exact integer model and queued. Each result is checked against the oldest
// queued prediction. Frame sizes are written only once the pipeline has drained. The run
// goes through zero, minimum, reset, maximum and random sizes.
module equirect_to_cube_face_coords_tb;
   import e2c_pkg::*;

   localparam int PipeLat = 16 + 23;      // drain allowance for write_frame and the end of the run
   localparam int CycleLimit = 400000;

   typedef struct {
      logic [21:0] src_x;
      logic [21:0] src_y;
   } coord_type;

   typedef struct {
      logic [1:0]  face;
      logic [9:0]  row;
      logic [9:0]  col;
      bit          typed;   // expected value typed in below (zero frame size rows)
      logic [21:0] src_x;
      logic [21:0] src_y;
   } pixel_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;    // [1:0] face, [11:2] row, [21:12] col
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;         // [21:0] src_x, [43:22] src_y
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [0:0]  csr_index = '0;
   logic [13:0] csr_data = '0;

   // frame sizes as the block should hold them
   logic [13:0] width_now, height_now;
   coord_type   coords_due[$];
   int          send_idle_pct, stall_pct;
   int          hold_requests, errors, pixels_sent, coords_seen, cycles;

   const int arctan_turns[17] = '{32768, 19344, 10221, 5188, 2604, 1303, 652, 326,
                                  163, 81, 41, 20, 10, 5, 3, 1, 1};

   // zero frame size gives coordinate 0 whatever the pixel
   const pixel_row_type pixel_table[18] = '{
      '{FaceLeft,    10'd0,    10'd0,    1'b1, 22'd0, 22'd0},
      '{FaceFront,   10'd1023, 10'd1023, 1'b1, 22'd0, 22'd0},
      '{FaceRight,   10'd512,  10'd0,    1'b1, 22'd0, 22'd0},
      '{2'd3,        10'd1023, 10'd0,    1'b1, 22'd0, 22'd0},
      '{FaceLeft,    10'd0,    10'd0,    1'b0, 22'd0, 22'd0},
      '{FaceLeft,    10'd1023, 10'd1023, 1'b0, 22'd0, 22'd0},
      '{FaceLeft,    10'd512,  10'd512,  1'b0, 22'd0, 22'd0},
      '{FaceFront,   10'd0,    10'd0,    1'b0, 22'd0, 22'd0},
      '{FaceFront,   10'd512,  10'd512,  1'b0, 22'd0, 22'd0},
      '{FaceFront,   10'd1023, 10'd0,    1'b0, 22'd0, 22'd0},
      '{FaceFront,   10'd0,    10'd1023, 1'b0, 22'd0, 22'd0},
      '{FaceRight,   10'd0,    10'd0,    1'b0, 22'd0, 22'd0},
      '{FaceRight,   10'd1023, 10'd1023, 1'b0, 22'd0, 22'd0},
      '{FaceRight,   10'd512,  10'd512,  1'b0, 22'd0, 22'd0},
      '{2'd3,        10'd512,  10'd512,  1'b0, 22'd0, 22'd0},   // unused face code
      '{2'd3,        10'd0,    10'd1023, 1'b0, 22'd0, 22'd0},
      '{FaceFront,   10'd511,  10'd513,  1'b0, 22'd0, 22'd0},
      '{FaceLeft,    10'd341,  10'd682,  1'b0, 22'd0, 22'd0}
   };

   equirect_to_cube_face_coords uut (.*);

   always #6 clock = ~clock;

   // ---------------- prediction ----------------

   function automatic longint floor_shift(longint v, int s);
      return v >>> s;   // arithmetic shift is floor for two's complement
   endfunction

   function automatic longint isqrt64(longint n);
      longint root, bitv;
      root = 0;
      bitv = 64'd1 << 36;
      while (bitv != 0) begin
         if (n >= root + bitv) begin
            n = n - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   // atan2(yv, xv) in 2^-18 turn, saturated to 18-bit signed
   function automatic longint vector_angle(longint yv, longint xv);
      longint cx, cy, acc, tmp, dx, dy;
      cx = xv * 256;
      cy = yv * 256;
      acc = 0;
      if (cx == 0 && cy == 0)
         return 0;
      if (cx < 0) begin
         tmp = cx;
         if (cy >= 0) begin
            cx = cy;  cy = -tmp; acc = 65536;
         end else begin
            cx = -cy; cy = tmp;  acc = -65536;
         end
      end
      for (int i = 0; i < 16; i++) begin
         dx = floor_shift(cy, i);
         dy = floor_shift(cx, i);
         if (cy >= 0) begin
            cx += dx; cy -= dy; acc += arctan_turns[i];
         end else begin
            cx -= dx; cy += dy; acc -= arctan_turns[i];
         end
      end
      if (acc > 131071) acc = 131071;
      if (acc < -131072) acc = -131072;
      return acc;
   endfunction

   function automatic logic [21:0] scale_to_frame(longint frac, int shift, logic [13:0] size);
      longint val, lim;
      val = (frac * longint'(size) + (longint'(1) << (shift - 1))) >> shift;
      lim = longint'(size) << 8;
      if (val > lim) val = lim;
      if (val > 4194303) val = 4194303;
      return val[21:0];
   endfunction

   function automatic coord_type source_coord(logic [1:0] face, logic [9:0] row,
                                              logic [9:0] col);
      longint nx, ny, vx, vy, vz, radius, lon, lat;
      coord_type c;
      ny = longint'(row) * 128 - 65536;   // row * 2^17 / 1024 - 1.0
      nx = longint'(col) * 128 - 65536;
      vy = ny;
      case (face)
         FaceLeft: begin
            vx = -65536; vz = nx;
         end
         FaceRight: begin
            vx = 65536;  vz = -nx;
         end
         default: begin   // front, and the unused code
            vx = nx;     vz = 65536;
         end
      endcase
      radius = isqrt64(vx * vx + vz * vz);
      lon = vector_angle(vx, vz);
      lat = vector_angle(vy, radius);
      c.src_x = scale_to_frame(lon + 131072, 10, width_now);
      c.src_y = scale_to_frame(lat + 65536, 9, height_now);
      return c;
   endfunction

   // ---------------- stimulus helpers ----------------

   task automatic send_pixel(logic [1:0] face, logic [9:0] row, logic [9:0] col,
                             bit typed = 0, logic [21:0] tx = 0, logic [21:0] ty = 0);
      coord_type c;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {2'b00, col, row, face};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      c = source_coord(face, row, col);
      if (typed) begin
         c.src_x = tx;
         c.src_y = ty;
      end
      coords_due.push_back(c);
      pixels_sent++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (coords_due.size() != 0) @(posedge clock);
   endtask

   task automatic write_frame(logic [0:0] idx, logic [13:0] val);
      drain();
      repeat (PipeLat + 8) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == CsrWidth) width_now = val;
      else height_now = val;
   endtask

   task automatic random_pixels(int n);
      for (int i = 0; i < n; i++)
         send_pixel(2'($urandom_range(3)), 10'($urandom_range(1023)),
                    10'($urandom_range(1023)));
   endtask

   // ---------------- result side ----------------

   // stalls at random; a long hold-off when the stimulus asks for one
   int hold_left = 0, holds_seen = 0;
   always @(posedge clock) begin
      if (hold_requests != holds_seen) begin
         holds_seen = hold_requests;
         hold_left = 300;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !reset && ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      coord_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         coords_seen++;
         if (coords_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected transaction src_x=%0d src_y=%0d", $time,
                     rsp_tdata[21:0], rsp_tdata[43:22]);
         end else begin
            want = coords_due.pop_front();
            if (rsp_tdata[21:0] !== want.src_x) begin
               errors++;
               $display("%0t: src_x expected %0d actual %0d", $time, want.src_x,
                        rsp_tdata[21:0]);
            end
            if (rsp_tdata[43:22] !== want.src_y) begin
               errors++;
               $display("%0t: src_y expected %0d actual %0d", $time, want.src_y,
                        rsp_tdata[43:22]);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("%0t: timeout, %0d transactions outstanding", $time, coords_due.size());
         $display("equirect_to_cube_face_coords test failed");
         $finish;
      end
   end

   // ---------------- main sequence ----------------

   initial begin
      errors = 0; pixels_sent = 0; coords_seen = 0; cycles = 0; hold_requests = 0;
      send_idle_pct = 0; stall_pct = 0;
      width_now = 14'd3840;
      height_now = 14'd1920;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset sizes first, then zero size with typed results
      foreach (pixel_table[i])
         if (!pixel_table[i].typed)
            send_pixel(pixel_table[i].face, pixel_table[i].row, pixel_table[i].col);
      write_frame(CsrWidth, 14'd0);
      write_frame(CsrHeight, 14'd0);
      foreach (pixel_table[i])
         if (pixel_table[i].typed)
            send_pixel(pixel_table[i].face, pixel_table[i].row, pixel_table[i].col,
                       1'b1, pixel_table[i].src_x, pixel_table[i].src_y);
      write_frame(CsrWidth, 14'd1);
      write_frame(CsrHeight, 14'd1);
      foreach (pixel_table[i])
         send_pixel(pixel_table[i].face, pixel_table[i].row, pixel_table[i].col);
      write_frame(CsrWidth, 14'd16383);   // every data bit set
      write_frame(CsrHeight, 14'd8192);
      foreach (pixel_table[i])
         send_pixel(pixel_table[i].face, pixel_table[i].row, pixel_table[i].col);

      // random part: four idling phases, each on its own frame size
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 75; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 75; end
            default: begin send_idle_pct = 17; stall_pct = 17; end
         endcase
         write_frame(CsrWidth, ph == 0 ? 14'd8192 : 14'($urandom_range(1, 8192)));
         write_frame(CsrHeight, ph == 3 ? 14'd3840 : 14'($urandom_range(1, 8192)));
         if (ph == 0) begin
            // back-pressure: result side held off while pixels keep coming
            hold_requests++;
            random_pixels(100);
            drain();   // sender waits for every result
         end
         random_pixels(220);
      end

      drain();
      repeat (PipeLat + 10) @(posedge clock);
      $display("%0d pixels over four faces codes, zero/min/max/random frame sizes,",
               pixels_sent);
      $display("%0d results checked under mixed idling and a long hold-off", coords_seen);
      if (errors == 0 && coords_due.size() == 0)
         $display("equirect_to_cube_face_coords test passed");
      else
         $display("equirect_to_cube_face_coords test failed");
      $finish;
   end
endmodule

### filelist.f
+incdir+rtl/core
rtl/core/e2c_pkg.sv
rtl/core/e2c_cordic_cell.sv
rtl/core/e2c_sqrt_cell.sv
rtl/core/equirect_to_cube_face_coords.sv
tb/sv/equirect_to_cube_face_coords_tb.sv
